// ===== design/ppg_heart_rate_zone_monitor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ppg_heart_rate_zone_monitor_unit assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef PPG_HEART_RATE_ZONE_MONITOR_UNIT_ASSERT_SVH
`define PPG_HEART_RATE_ZONE_MONITOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HRZ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrz check failed");

`define HRZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrz check failed");

`else

`define HRZ_ASSERT_IMPL(label, clk, rst, ante, cons)

`define HRZ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/hrz_pkg.sv =====
// ----------------------------------------------------------------------------
// hrz_pkg
// Shared types and constants of the heart rate zone monitor.
// ----------------------------------------------------------------------------
package hrz_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 14;
  localparam int BPM_W      = 12;
  localparam int RATE_SUM_W = 15;
  localparam int ZONE_W     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIVIDEND_W = 20;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [DIVIDEND_W-1:0] RATE_NUMERATOR = DIVIDEND_W'(960000);
  localparam logic [BPM_W-1:0]      BPM_MAX        = {BPM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST_LIMIT     = 2'd0,
    REG_ELEVATED_LIMIT = 2'd1,
    REG_MIN_PEAK_GAP   = 2'd2,
    REG_PEAK_MARGIN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_NONE     = 2'd0,
    ZONE_RESTING  = 2'd1,
    ZONE_ELEVATED = 2'd2,
    ZONE_HIGH     = 2'd3
  } zone_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_PEAK,
    S_GAP,
    S_DIV,
    S_PUSH,
    S_MEAN,
    S_OUT
  } hrz_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/hrz_divider.sv =====
// ----------------------------------------------------------------------------
// hrz_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrz_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hrz_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [hrz_pkg::DIVISOR_W-1:0]   divisor,
  output hrz_pkg::div_status_t            status,
  output logic [hrz_pkg::DIVIDEND_W-1:0]  quotient
);
  import hrz_pkg::*;

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIV_CNT_W-1:0]  count;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = ~diff[DIVISOR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// ===== design/ppg_heart_rate_zone_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// ppg_heart_rate_zone_monitor_unit
// Pulse sample smoothing, peak picking, heart rate averaging and zone report.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata: sample[9:0], time_ms[41:10]
//  m_axis    out  tdata: smoothed_sum[13:0], peak_found[14],
//                        average_bpm_q4[26:15], zone[28:27]
//  cfg       in   cfg_we, cfg_index, cfg_wdata; write-only
//
//  Each beat steps through S_WIN, S_PEAK and S_GAP to S_OUT, which loads the
//  output once the output register is free, then back to S_IDLE. A beat that
//  yields a rate goes via the shared 20-step divider, which forms 960000 /
//  interval, and the rate mean is then taken by a reciprocal multiply.
//  s_tready is high only while idle; the output register holds a result until
//  taken, and the next beat is accepted meanwhile. Reset clears all history.
// ----------------------------------------------------------------------------
module ppg_heart_rate_zone_monitor_unit #(
  parameter int SMOOTH_TAPS = 10,
  parameter int RATE_TAPS   = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample[9:0], time_ms[41:10], zero fill above
  input  logic [47:0]                      s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // smoothed_sum[13:0], peak_found[14], average_bpm_q4[26:15], zone[28:27]
  output logic [31:0]                      m_tdata,
  input  logic                             cfg_we,
  input  logic [hrz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hrz_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hrz_pkg::*;

  localparam int SP_W = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
  localparam int RP_W = (RATE_TAPS > 1) ? $clog2(RATE_TAPS) : 1;

  localparam int PEAK_LSB = WIN_W;
  localparam int AVG_LSB  = WIN_W + 1;
  localparam int ZONE_LSB = AVG_LSB + BPM_W;
  localparam int OUT_USED = ZONE_LSB + ZONE_W;

  // truncating mean by reciprocal multiply, exact for every reachable total
  localparam int MEAN_SHIFT  = 18;
  localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + RATE_TAPS - 1) / RATE_TAPS;
  localparam int MEAN_PROD_W = RATE_SUM_W + MEAN_SHIFT + 1;

  // configuration
  logic [7:0]            rest_limit;
  logic [7:0]            elevated_limit;
  logic [15:0]           min_peak_gap;
  logic [WIN_W-1:0]      peak_margin;

  // history
  logic [SAMPLE_W-1:0]   sample_ring [SMOOTH_TAPS];
  logic [SP_W-1:0]       sample_pos;
  logic [WIN_W-1:0]      window_total;
  logic [WIN_W-1:0]      older_sum;
  logic [WIN_W-1:0]      middle_sum;
  logic [WIN_W-1:0]      newest_sum;
  logic [TIME_W-1:0]     last_peak_time;
  logic [BPM_W-1:0]      rate_ring [RATE_TAPS];
  logic [RP_W-1:0]       rate_pos;
  logic [RATE_SUM_W-1:0] rate_total;
  logic [BPM_W-1:0]      rate_average;

  // per-beat working registers
  hrz_state_t            state;
  hrz_state_t            state_next;
  logic [SAMPLE_W-1:0]   sample_in;
  logic [TIME_W-1:0]     time_in;
  logic [TIME_W-1:0]     gap;
  logic                  peak_cand;
  logic                  peak;

  // shared divider
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  div_status_t           div_stat;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic [WIN_W-1:0]      window_next;
  logic                  is_peak;
  logic                  gap_ok;
  logic                  have_peak;
  logic [BPM_W-1:0]      bpm;
  logic [RATE_SUM_W-1:0] rate_total_next;
  logic [MEAN_PROD_W-1:0] mean_prod;
  zone_t                 zone;
  logic                  out_free;

  hrz_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quotient)
  );

  always_comb begin
    window_next = window_total - {{(WIN_W-SAMPLE_W){1'b0}}, sample_ring[sample_pos]}
                  + {{(WIN_W-SAMPLE_W){1'b0}}, sample_in};
    is_peak = (middle_sum > older_sum) && (middle_sum > newest_sum) &&
              ((middle_sum - older_sum) > peak_margin) &&
              ((middle_sum - newest_sum) > peak_margin);
    gap_ok    = peak_cand && (gap > {16'd0, min_peak_gap});
    have_peak = (last_peak_time != '0);
    bpm = (div_quotient > {{(DIVIDEND_W-BPM_W){1'b0}}, BPM_MAX}) ?
          BPM_MAX : div_quotient[BPM_W-1:0];
    rate_total_next = rate_total - {{(RATE_SUM_W-BPM_W){1'b0}}, rate_ring[rate_pos]}
                      + {{(RATE_SUM_W-BPM_W){1'b0}}, bpm};
    mean_prod = MEAN_PROD_W'(rate_total) * MEAN_PROD_W'(MEAN_RECIP);
    out_free = !m_tvalid || m_tready;
  end

  always_comb begin
    if (rate_average == '0) begin
      zone = ZONE_NONE;
    end else if (rate_average < {rest_limit, 4'd0}) begin
      zone = ZONE_RESTING;
    end else if (rate_average < {elevated_limit, 4'd0}) begin
      zone = ZONE_ELEVATED;
    end else begin
      zone = ZONE_HIGH;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_WIN;
      S_WIN:     state_next = S_PEAK;
      S_PEAK:    state_next = S_GAP;
      S_GAP:     state_next = (gap_ok && have_peak) ? S_DIV : S_OUT;
      S_DIV:     if (div_stat.done) state_next = S_PUSH;
      S_PUSH:    state_next = S_MEAN;
      S_MEAN:    state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = RATE_NUMERATOR;
    div_divisor  = gap;
    unique case (state)
      S_IDLE:    s_tready = 1'b1;
      S_GAP:     div_start = gap_ok && have_peak;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rest_limit     <= 8'd90;
      elevated_limit <= 8'd120;
      min_peak_gap   <= 16'd300;
      peak_margin    <= '0;
      sample_pos     <= '0;
      window_total   <= '0;
      older_sum      <= '0;
      middle_sum     <= '0;
      newest_sum     <= '0;
      last_peak_time <= '0;
      rate_pos       <= '0;
      rate_total     <= '0;
      rate_average   <= '0;
      peak           <= 1'b0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < SMOOTH_TAPS; i++) sample_ring[i] <= '0;
      for (int i = 0; i < RATE_TAPS; i++) rate_ring[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_REST_LIMIT:     rest_limit     <= cfg_wdata[7:0];
          REG_ELEVATED_LIMIT: elevated_limit <= cfg_wdata[7:0];
          REG_MIN_PEAK_GAP:   min_peak_gap   <= cfg_wdata;
          REG_PEAK_MARGIN:    peak_margin    <= cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_tvalid) peak <= 1'b0;
        S_WIN: begin
          sample_ring[sample_pos] <= sample_in;
          window_total <= window_next;
          older_sum    <= middle_sum;
          middle_sum   <= newest_sum;
          newest_sum   <= window_next;
          sample_pos   <= (sample_pos == SP_W'(SMOOTH_TAPS - 1)) ? '0 : sample_pos + 1'b1;
        end
        S_GAP: if (gap_ok) begin
          last_peak_time <= time_in;
          peak           <= 1'b1;
        end
        S_PUSH: begin
          rate_ring[rate_pos] <= bpm;
          rate_total <= rate_total_next;
          rate_pos   <= (rate_pos == RP_W'(RATE_TAPS - 1)) ? '0 : rate_pos + 1'b1;
        end
        S_MEAN: rate_average <= mean_prod[MEAN_SHIFT +: BPM_W];
        default: ;
      endcase
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      sample_in <= s_tdata[SAMPLE_W-1:0];
      time_in   <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
    end
    if (state == S_PEAK) begin
      peak_cand <= is_peak;
      gap       <= time_in - last_peak_time;
    end
    if (state == S_OUT && out_free) begin
      m_tdata <= {{(32-OUT_USED){1'b0}}, zone, rate_average, peak, window_total};
    end
  end

  `include "ppg_heart_rate_zone_monitor_unit_assert.svh"

  `HRZ_ASSERT_IMPL(a_div_owned, clk, rst, div_stat.busy, state == S_DIV)
  `HRZ_ASSERT_IMPL(a_rate_pos, clk, rst, 1'b1, rate_pos <= RP_W'(RATE_TAPS - 1))
  `HRZ_ASSERT_IMPL(a_zone_avg, clk, rst, m_tvalid, (m_tdata[ZONE_LSB+ZONE_W-1:ZONE_LSB] == ZONE_NONE) == (m_tdata[ZONE_LSB-1:AVG_LSB] == '0))
  `HRZ_ASSERT_NEXT(a_busy_after_beat, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule
